>>> src/masked_sliding_median_filter_defines.svh
// ----------------------------------------------------------------------------
// masked sliding median filter assertion macros
// shared property wrappers, clocked on clk_i and quiet during reset
// ----------------------------------------------------------------------------
`ifndef MASKED_SLIDING_MEDIAN_FILTER_DEFINES_SVH
`define MASKED_SLIDING_MEDIAN_FILTER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define MSMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MSMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/msmf_pkg.sv
// ----------------------------------------------------------------------------
// msmf_pkg
// shared widths, reset values, sequencer states and rank step control
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msmf_pkg;

  localparam int WINDOW_DEF = 5;
  localparam int VAL_W      = 16;
  localparam int SRC_W      = 8;
  localparam int FRAME_W    = 32;
  localparam int MV_W       = 3;
  localparam int NUM_LANES  = 4;

  localparam logic [MV_W-1:0] MIN_VALID_RST = 3'd3;

  // lane order of the rank unit
  localparam int LANE_LINE_FIRST  = 0;
  localparam int LANE_LINE_SECOND = 1;
  localparam int LANE_END_FIRST   = 2;
  localparam int LANE_END_SECOND  = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_DRAIN,
    ST_WRITE
  } msmf_state_e;

  // control of one compare step, aligned with the registered memory reads
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic oth_before_cand;
    logic line_cand_ok;
    logic line_oth_ok;
    logic end_cand_ok;
    logic end_oth_ok;
  } msmf_step_t;

endpackage

>>> src/masked_sliding_median_filter.sv
// ----------------------------------------------------------------------------
// masked_sliding_median_filter
// two ring windows of recent line parameters; outputs the upper median of
// the valid window entries once enough of them are present
// ----------------------------------------------------------------------------
// channel  dir  handshake                  payload
// in       in   in_valid_i / in_stall_o    source_id_i .. end_second_i
// out      out  out_valid_o / out_stall_i  line_first_out_o .. frame_count_o
// cfg      in   cfg_valid_i / cfg_ready_o  cfg_data_i (min_valid)
//
// an item that needs a median passes through the rank, drain and write states:
// the rank unit compares every pair of window entries, one pair a cycle
// an item that passes raw goes from idle straight to the write state
// reset clears positions, fills and flags at once, no clearing pass
// a stalled output holds the block only while the output register is full
`timescale 1ns / 1ps
`include "masked_sliding_median_filter_defines.svh"

module masked_sliding_median_filter
  import msmf_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [SRC_W-1:0]        source_id_i,
  input  logic signed [VAL_W-1:0] line_first_i,
  input  logic signed [VAL_W-1:0] line_second_i,
  input  logic                    line_ok_i,
  input  logic                    end_present_i,
  input  logic signed [VAL_W-1:0] end_first_i,
  input  logic signed [VAL_W-1:0] end_second_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] line_first_out_o,
  output logic signed [VAL_W-1:0] line_second_out_o,
  output logic                    line_smoothed_o,
  output logic                    end_present_out_o,
  output logic signed [VAL_W-1:0] end_first_out_o,
  output logic signed [VAL_W-1:0] end_second_out_o,
  output logic                    end_smoothed_o,
  output logic [FRAME_W-1:0]      frame_count_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [MV_W-1:0]         cfg_data_i
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int CMP_W = (CNT_W > MV_W) ? CNT_W : MV_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW);

  msmf_state_e state_q, state_d;

  logic [MV_W-1:0]    min_valid_q;
  logic [SRC_W-1:0]   prev_src_q;
  logic [FRAME_W-1:0] frame_cnt_q;
  logic [IDX_W-1:0]   line_pos_q, end_pos_q;
  logic [CNT_W-1:0]   line_fill_q, end_fill_q, line_cnt_q;
  logic [WINDOW-1:0]  line_ok_q;
  logic [WINDOW-1:0]  line_vld, end_vld;

  logic [2*VAL_W-1:0] line_mem [WINDOW];
  logic [2*VAL_W-1:0] end_mem  [WINDOW];
  logic [2*VAL_W-1:0] line_rd_cand_q, line_rd_oth_q, end_rd_cand_q, end_rd_oth_q;

  logic [IDX_W-1:0] i_q, j_q;
  msmf_step_t       step_d, step_q;

  // item registers
  logic signed [VAL_W-1:0] raw_lf_q, raw_ls_q, raw_ef_q, raw_es_q;
  logic                    ep_q, line_sm_q, end_sm_q;
  logic [CNT_W-1:0]        line_tgt_q, end_tgt_q;

  // output register
  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_lf_q, out_ls_q, out_ef_q, out_es_q;
  logic                    out_lsm_q, out_ep_q, out_esm_q;
  logic [FRAME_W-1:0]      out_frame_q;

  logic                    accept, rank_issue, out_free, out_load;
  logic                    src_chg, old_ok, line_sm_new, end_sm_new;
  logic [IDX_W-1:0]        line_base_pos, line_pos_new, end_pos_new;
  logic [CNT_W-1:0]        line_base_fill, line_base_cnt, line_fill_new, line_cnt_new;
  logic [CNT_W-1:0]        end_fill_new;
  logic signed [VAL_W-1:0] med [NUM_LANES];

  // entry validity: written since the last clear, and flagged ok for lines
  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      line_vld[k] = line_ok_q[k] && (CNT_W'(k) < line_fill_q);
      end_vld[k]  = CNT_W'(k) < end_fill_q;
    end
  end

  // window update for the item being accepted
  always_comb begin
    src_chg        = source_id_i != prev_src_q;
    line_base_pos  = src_chg ? '0 : line_pos_q;
    line_base_fill = src_chg ? '0 : line_fill_q;
    line_base_cnt  = src_chg ? '0 : line_cnt_q;
    old_ok         = src_chg ? 1'b0 : line_vld[line_pos_q];
    line_pos_new   = (line_base_pos == LAST_IDX) ? '0 : line_base_pos + IDX_W'(1);
    line_fill_new  = (line_base_fill == FULL_CNT) ? FULL_CNT
                                                  : line_base_fill + CNT_W'(1);
    line_cnt_new   = line_base_cnt - CNT_W'(old_ok) + CNT_W'(line_ok_i);
    if (end_present_i) begin
      end_pos_new  = (end_pos_q == LAST_IDX) ? '0 : end_pos_q + IDX_W'(1);
      end_fill_new = (end_fill_q == FULL_CNT) ? FULL_CNT : end_fill_q + CNT_W'(1);
    end else begin
      end_pos_new  = '0;
      end_fill_new = '0;
    end
    line_sm_new = line_ok_i && (CMP_W'(line_cnt_new) >= CMP_W'(min_valid_q));
    end_sm_new  = end_present_i && (CMP_W'(end_fill_new) >= CMP_W'(min_valid_q));
  end

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (line_sm_new || end_sm_new) ? ST_RANK : ST_WRITE;
        end
      end
      ST_RANK: begin
        if ((i_q == LAST_IDX) && (j_q == LAST_IDX)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall_o = 1'b1;
    rank_issue = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_stall_o = 1'b0;
      ST_RANK:  rank_issue = 1'b1;
      ST_DRAIN: ;
      ST_WRITE: out_load   = out_free;
      default:  ;
    endcase
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    step_d.vld             = rank_issue;
    step_d.first           = j_q == '0;
    step_d.last            = j_q == LAST_IDX;
    step_d.oth_before_cand = j_q < i_q;
    step_d.line_cand_ok    = line_vld[i_q];
    step_d.line_oth_ok     = line_vld[j_q];
    step_d.end_cand_ok     = end_vld[i_q];
    step_d.end_oth_ok      = end_vld[j_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      min_valid_q <= MIN_VALID_RST;
      prev_src_q  <= '0;
      frame_cnt_q <= '0;
      line_pos_q  <= '0;
      line_fill_q <= '0;
      line_cnt_q  <= '0;
      line_ok_q   <= '0;
      end_pos_q   <= '0;
      end_fill_q  <= '0;
      i_q         <= '0;
      j_q         <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (cfg_valid_i) begin
        min_valid_q <= cfg_data_i;
      end
      if (accept) begin
        prev_src_q               <= source_id_i;
        frame_cnt_q              <= frame_cnt_q + FRAME_W'(1);
        line_ok_q[line_base_pos] <= line_ok_i;
        line_pos_q               <= line_pos_new;
        line_fill_q              <= line_fill_new;
        line_cnt_q               <= line_cnt_new;
        end_pos_q                <= end_pos_new;
        end_fill_q               <= end_fill_new;
        i_q                      <= '0;
        j_q                      <= '0;
      end else if (rank_issue) begin
        if (j_q == LAST_IDX) begin
          j_q <= '0;
          i_q <= (i_q == LAST_IDX) ? '0 : i_q + IDX_W'(1);
        end else begin
          j_q <= j_q + IDX_W'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // window memories: one write each, candidate and other read each cycle while ranking
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem[line_base_pos] <= {line_first_i, line_second_i};
    end
    if (accept && end_present_i) begin
      end_mem[end_pos_q] <= {end_first_i, end_second_i};
    end
    if (rank_issue) begin
      line_rd_cand_q <= line_mem[i_q];
      line_rd_oth_q  <= line_mem[j_q];
      end_rd_cand_q  <= end_mem[i_q];
      end_rd_oth_q   <= end_mem[j_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_lf_q   <= line_first_i;
      raw_ls_q   <= line_second_i;
      raw_ef_q   <= end_first_i;
      raw_es_q   <= end_second_i;
      ep_q       <= end_present_i;
      line_sm_q  <= line_sm_new;
      end_sm_q   <= end_sm_new;
      line_tgt_q <= line_cnt_new >> 1;
      end_tgt_q  <= end_fill_new >> 1;
    end
    if (out_load) begin
      out_lf_q    <= line_sm_q ? med[LANE_LINE_FIRST]  : raw_lf_q;
      out_ls_q    <= line_sm_q ? med[LANE_LINE_SECOND] : raw_ls_q;
      out_ef_q    <= end_sm_q  ? med[LANE_END_FIRST]   : raw_ef_q;
      out_es_q    <= end_sm_q  ? med[LANE_END_SECOND]  : raw_es_q;
      out_lsm_q   <= line_sm_q;
      out_ep_q    <= ep_q;
      out_esm_q   <= end_sm_q;
      out_frame_q <= frame_cnt_q;
    end
  end

  msmf_rank #(
    .WINDOW (WINDOW)
  ) u_rank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step_q),
    .line_cand_i (line_rd_cand_q),
    .line_oth_i  (line_rd_oth_q),
    .end_cand_i  (end_rd_cand_q),
    .end_oth_i   (end_rd_oth_q),
    .line_tgt_i  (line_tgt_q),
    .end_tgt_i   (end_tgt_q),
    .med_o       (med)
  );

  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign line_first_out_o  = out_lf_q;
  assign line_second_out_o = out_ls_q;
  assign line_smoothed_o   = out_lsm_q;
  assign end_present_out_o = out_ep_q;
  assign end_first_out_o   = out_ef_q;
  assign end_second_out_o  = out_es_q;
  assign end_smoothed_o    = out_esm_q;
  assign frame_count_o     = out_frame_q;

  `MSMF_ASSERT_NEXT(a_accept_starts_work, accept,
    (state_q == ST_RANK) || (state_q == ST_WRITE), "accepted item did not start work")
  `MSMF_ASSERT_NOW(a_fill_in_range, 1'b1,
    (line_fill_q <= FULL_CNT) && (end_fill_q <= FULL_CNT), "window fill beyond depth")
  `MSMF_ASSERT_NOW(a_count_le_fill, 1'b1,
    line_cnt_q <= line_fill_q, "valid count exceeds line fill")
  `MSMF_ASSERT_NEXT(a_out_only_from_write, !out_valid_q && (state_q != ST_WRITE),
    !out_valid_q, "result shown without a write step")

endmodule

>>> src/msmf_rank.sv
// ----------------------------------------------------------------------------
// msmf_rank
// shared four-lane rank unit: one candidate/other compare per lane per cycle,
// keeps the candidate whose rank among the valid entries equals the target
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msmf_rank
  import msmf_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  localparam int CNT_W = $clog2(WINDOW + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  msmf_step_t              step_i,
  input  logic [2*VAL_W-1:0]      line_cand_i,
  input  logic [2*VAL_W-1:0]      line_oth_i,
  input  logic [2*VAL_W-1:0]      end_cand_i,
  input  logic [2*VAL_W-1:0]      end_oth_i,
  input  logic [CNT_W-1:0]        line_tgt_i,
  input  logic [CNT_W-1:0]        end_tgt_i,
  output logic signed [VAL_W-1:0] med_o [NUM_LANES]
);

  logic signed [VAL_W-1:0] cand    [NUM_LANES];
  logic signed [VAL_W-1:0] oth     [NUM_LANES];
  logic                    cand_ok [NUM_LANES];
  logic                    oth_ok  [NUM_LANES];
  logic [CNT_W-1:0]        tgt     [NUM_LANES];
  logic [CNT_W-1:0]        rank    [NUM_LANES];
  logic [CNT_W-1:0]        acc_q   [NUM_LANES];
  logic signed [VAL_W-1:0] med_q   [NUM_LANES];

  always_comb begin
    cand[LANE_LINE_FIRST]     = line_cand_i[2*VAL_W-1:VAL_W];
    cand[LANE_LINE_SECOND]    = line_cand_i[VAL_W-1:0];
    cand[LANE_END_FIRST]      = end_cand_i[2*VAL_W-1:VAL_W];
    cand[LANE_END_SECOND]     = end_cand_i[VAL_W-1:0];
    oth[LANE_LINE_FIRST]      = line_oth_i[2*VAL_W-1:VAL_W];
    oth[LANE_LINE_SECOND]     = line_oth_i[VAL_W-1:0];
    oth[LANE_END_FIRST]       = end_oth_i[2*VAL_W-1:VAL_W];
    oth[LANE_END_SECOND]      = end_oth_i[VAL_W-1:0];
    cand_ok[LANE_LINE_FIRST]  = step_i.line_cand_ok;
    cand_ok[LANE_LINE_SECOND] = step_i.line_cand_ok;
    cand_ok[LANE_END_FIRST]   = step_i.end_cand_ok;
    cand_ok[LANE_END_SECOND]  = step_i.end_cand_ok;
    oth_ok[LANE_LINE_FIRST]   = step_i.line_oth_ok;
    oth_ok[LANE_LINE_SECOND]  = step_i.line_oth_ok;
    oth_ok[LANE_END_FIRST]    = step_i.end_oth_ok;
    oth_ok[LANE_END_SECOND]   = step_i.end_oth_ok;
    tgt[LANE_LINE_FIRST]      = line_tgt_i;
    tgt[LANE_LINE_SECOND]     = line_tgt_i;
    tgt[LANE_END_FIRST]       = end_tgt_i;
    tgt[LANE_END_SECOND]      = end_tgt_i;
  end

  // ties broken by entry index so ranks form a permutation of 0..n-1
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      rank[k] = (step_i.first ? '0 : acc_q[k]) +
                CNT_W'(oth_ok[k] && ((oth[k] < cand[k]) ||
                                     ((oth[k] == cand[k]) && step_i.oth_before_cand)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        acc_q[k] <= '0;
        med_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_LANES; k++) begin
        if (step_i.vld) begin
          acc_q[k] <= rank[k];
          if (step_i.last && cand_ok[k] && (rank[k] == tgt[k])) begin
            med_q[k] <= cand[k];
          end
        end
      end
    end
  end

  assign med_o = med_q;

endmodule

>>> dv/tb_masked_sliding_median_filter.sv
// ----------------------------------------------------------------------------
// tb_masked_sliding_median_filter
// Drives camera frames into the median filter and checks every result
// against a predictor that keeps its own control and end-line windows.
// Covers field extremes, source changes, missing end lines and invalid
// control lines. Runs min_valid settings zero to five and seven under
// random sender bursts, receiver stalls, a long output hold-off and a full
// drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_masked_sliding_median_filter;
  import msmf_pkg::*;

  localparam int WIN = WINDOW_DEF;

  typedef struct packed {
    logic [SRC_W-1:0]        source_id;
    logic signed [VAL_W-1:0] line_first;
    logic signed [VAL_W-1:0] line_second;
    logic                    line_ok;
    logic                    end_present;
    logic signed [VAL_W-1:0] end_first;
    logic signed [VAL_W-1:0] end_second;
  } frame_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] line_first_out;
    logic signed [VAL_W-1:0] line_second_out;
    logic                    line_smoothed;
    logic                    end_present_out;
    logic signed [VAL_W-1:0] end_first_out;
    logic signed [VAL_W-1:0] end_second_out;
    logic                    end_smoothed;
    logic [FRAME_W-1:0]      frame_count;
  } filtered_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [SRC_W-1:0]        source_id_i = '0;
  logic signed [VAL_W-1:0] line_first_i = '0;
  logic signed [VAL_W-1:0] line_second_i = '0;
  logic                    line_ok_i = 1'b0;
  logic                    end_present_i = 1'b0;
  logic signed [VAL_W-1:0] end_first_i = '0;
  logic signed [VAL_W-1:0] end_second_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [VAL_W-1:0] line_first_out_o;
  logic signed [VAL_W-1:0] line_second_out_o;
  logic                    line_smoothed_o;
  logic                    end_present_out_o;
  logic signed [VAL_W-1:0] end_first_out_o;
  logic signed [VAL_W-1:0] end_second_out_o;
  logic                    end_smoothed_o;
  logic [FRAME_W-1:0]      frame_count_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [MV_W-1:0]         cfg_data_i = '0;

  always #2 clk_i = ~clk_i;

  masked_sliding_median_filter #(
    .WINDOW(WIN)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .source_id_i      (source_id_i),
    .line_first_i     (line_first_i),
    .line_second_i    (line_second_i),
    .line_ok_i        (line_ok_i),
    .end_present_i    (end_present_i),
    .end_first_i      (end_first_i),
    .end_second_i     (end_second_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .line_first_out_o (line_first_out_o),
    .line_second_out_o(line_second_out_o),
    .line_smoothed_o  (line_smoothed_o),
    .end_present_out_o(end_present_out_o),
    .end_first_out_o  (end_first_out_o),
    .end_second_out_o (end_second_out_o),
    .end_smoothed_o   (end_smoothed_o),
    .frame_count_o    (frame_count_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  // predictor state: one value column per rank lane
  logic signed [VAL_W-1:0] win_val [NUM_LANES][WIN];
  bit                      ln_ok [WIN];
  int                      ln_pos = 0;
  int                      ln_fill = 0;
  int                      en_pos = 0;
  int                      en_fill = 0;
  logic [SRC_W-1:0]        last_src = '0;
  logic [FRAME_W-1:0]      frames_seen = '0;
  logic [MV_W-1:0]         min_valid_cfg = MIN_VALID_RST;

  filtered_t               pending_filtered_q[$];
  int                      n_fail = 0;
  logic [SRC_W-1:0]        cur_src = '0;

  // receiver stall control
  int                      hold_req = 0;
  int                      hold_left = 0;
  int                      seg_left = 0;
  int                      stall_pct = 0;

  initial begin
    for (int l = 0; l < NUM_LANES; l++)
      for (int i = 0; i < WIN; i++)
        win_val[l][i] = '0;
    for (int i = 0; i < WIN; i++)
      ln_ok[i] = 1'b0;
  end

  // upper median over the counted entries of one lane
  function automatic logic signed [VAL_W-1:0] window_median(input int lane);
    logic signed [VAL_W-1:0] sorted [WIN];
    logic signed [VAL_W-1:0] t;
    int n;
    int fill;
    int j;
    bit is_line;
    is_line = (lane == LANE_LINE_FIRST) || (lane == LANE_LINE_SECOND);
    fill = is_line ? ln_fill : en_fill;
    n = 0;
    for (int i = 0; i < fill; i++) begin
      if (!is_line || ln_ok[i]) begin
        sorted[n] = win_val[lane][i];
        n++;
      end
    end
    if (n == 0) return '0;
    for (int i = 1; i < n; i++) begin
      t = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > t) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = t;
    end
    return sorted[n/2];
  endfunction

  function automatic filtered_t filter_frame(input frame_t f);
    filtered_t r;
    int n_ok;
    if (f.source_id != last_src) begin
      for (int i = 0; i < WIN; i++) begin
        win_val[LANE_LINE_FIRST][i] = '0;
        win_val[LANE_LINE_SECOND][i] = '0;
        ln_ok[i] = 1'b0;
      end
      ln_pos = 0;
      ln_fill = 0;
      last_src = f.source_id;
    end
    // an invalid line still takes a slot, flagged off
    win_val[LANE_LINE_FIRST][ln_pos] = f.line_first;
    win_val[LANE_LINE_SECOND][ln_pos] = f.line_second;
    ln_ok[ln_pos] = f.line_ok;
    ln_pos = (ln_pos + 1) % WIN;
    if (ln_fill < WIN) ln_fill++;

    r.line_first_out = f.line_first;
    r.line_second_out = f.line_second;
    r.line_smoothed = 1'b0;
    n_ok = 0;
    for (int i = 0; i < ln_fill; i++)
      if (ln_ok[i]) n_ok++;
    if (f.line_ok && n_ok >= int'(min_valid_cfg)) begin
      r.line_first_out = window_median(LANE_LINE_FIRST);
      r.line_second_out = window_median(LANE_LINE_SECOND);
      r.line_smoothed = 1'b1;
    end

    if (f.end_present) begin
      win_val[LANE_END_FIRST][en_pos] = f.end_first;
      win_val[LANE_END_SECOND][en_pos] = f.end_second;
      en_pos = (en_pos + 1) % WIN;
      if (en_fill < WIN) en_fill++;
    end else begin
      for (int i = 0; i < WIN; i++) begin
        win_val[LANE_END_FIRST][i] = '0;
        win_val[LANE_END_SECOND][i] = '0;
      end
      en_pos = 0;
      en_fill = 0;
    end
    r.end_present_out = f.end_present;
    r.end_first_out = f.end_first;
    r.end_second_out = f.end_second;
    r.end_smoothed = 1'b0;
    if (f.end_present && en_fill >= int'(min_valid_cfg)) begin
      r.end_first_out = window_median(LANE_END_FIRST);
      r.end_second_out = window_median(LANE_END_SECOND);
      r.end_smoothed = 1'b1;
    end

    frames_seen++;
    r.frame_count = frames_seen;
    return r;
  endfunction

  function automatic frame_t mk_frame(input logic [SRC_W-1:0] src,
                                      input logic signed [VAL_W-1:0] lf,
                                      input logic signed [VAL_W-1:0] ls,
                                      input logic ok, input logic ep,
                                      input logic signed [VAL_W-1:0] ef,
                                      input logic signed [VAL_W-1:0] es);
    frame_t f;
    f.source_id = src;
    f.line_first = lf;
    f.line_second = ls;
    f.line_ok = ok;
    f.end_present = ep;
    f.end_first = ef;
    f.end_second = es;
    return f;
  endfunction

  // extremes, clustered values for ties, and full-range noise
  function automatic logic signed [VAL_W-1:0] pick_param();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2, 3, 4: return VAL_W'(int'($urandom_range(0, 40)) - 20);
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // mostly one source with valid lines and end-line runs, some noise
  function automatic frame_t random_frame();
    frame_t f;
    if ($urandom_range(0, 99) < 8) begin
      f = frame_t'({$urandom, $urandom, $urandom});
    end else begin
      if ($urandom_range(0, 99) < 4) cur_src = SRC_W'($urandom);
      f.source_id = cur_src;
      f.line_first = pick_param();
      f.line_second = pick_param();
      f.line_ok = ($urandom_range(0, 99) < 80);
      f.end_present = ($urandom_range(0, 99) < 88);
      f.end_first = pick_param();
      f.end_second = pick_param();
    end
    return f;
  endfunction

  task automatic send_frame(input frame_t f);
    in_valid_i <= 1'b1;
    source_id_i <= f.source_id;
    line_first_i <= f.line_first;
    line_second_i <= f.line_second;
    line_ok_i <= f.line_ok;
    end_present_i <= f.end_present;
    end_first_i <= f.end_first;
    end_second_i <= f.end_second;
    do @(posedge clk_i); while (in_stall_o);
    pending_filtered_q.push_back(filter_frame(f));
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_bursts(input int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      if (burst > left) burst = left;
      repeat (burst) send_frame(random_frame());
      left -= burst;
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 30));
    end
  endtask

  task automatic wait_all_filtered();
    in_valid_i <= 1'b0;
    while (pending_filtered_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_min_valid(input logic [MV_W-1:0] v);
    wait_all_filtered();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    min_valid_cfg = v;
  endtask

  task automatic flag_field(input string what, input logic [FRAME_W-1:0] want,
                            input logic [FRAME_W-1:0] got);
    n_fail++;
    if (n_fail <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  task automatic check_filtered(input filtered_t want, input filtered_t got);
    if (got.line_first_out !== want.line_first_out)
      flag_field("line_first_out", FRAME_W'(want.line_first_out),
                 FRAME_W'(got.line_first_out));
    if (got.line_second_out !== want.line_second_out)
      flag_field("line_second_out", FRAME_W'(want.line_second_out),
                 FRAME_W'(got.line_second_out));
    if (got.line_smoothed !== want.line_smoothed)
      flag_field("line_smoothed", FRAME_W'(want.line_smoothed),
                 FRAME_W'(got.line_smoothed));
    if (got.end_present_out !== want.end_present_out)
      flag_field("end_present_out", FRAME_W'(want.end_present_out),
                 FRAME_W'(got.end_present_out));
    if (got.end_first_out !== want.end_first_out)
      flag_field("end_first_out", FRAME_W'(want.end_first_out),
                 FRAME_W'(got.end_first_out));
    if (got.end_second_out !== want.end_second_out)
      flag_field("end_second_out", FRAME_W'(want.end_second_out),
                 FRAME_W'(got.end_second_out));
    if (got.end_smoothed !== want.end_smoothed)
      flag_field("end_smoothed", FRAME_W'(want.end_smoothed),
                 FRAME_W'(got.end_smoothed));
    if (got.frame_count !== want.frame_count)
      flag_field("frame_count", want.frame_count, got.frame_count);
  endtask

  always @(posedge clk_i) begin
    filtered_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.line_first_out = line_first_out_o;
      got.line_second_out = line_second_out_o;
      got.line_smoothed = line_smoothed_o;
      got.end_present_out = end_present_out_o;
      got.end_first_out = end_first_out_o;
      got.end_second_out = end_second_out_o;
      got.end_smoothed = end_smoothed_o;
      got.frame_count = frame_count_o;
      if (pending_filtered_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("result item with no frame pending, frame_count %h", frame_count_o);
      end else begin
        check_filtered(pending_filtered_q.pop_front(), got);
      end
    end
  end

  // receiver: segments of random stall density, or a requested long hold-off
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 64);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      seg_left--;
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic test_directed();
    frame_t dir_q[$];
    // first frames fill the windows from entry zero at the reset threshold
    dir_q.push_back(mk_frame(8'h00, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1, 16'sh8000, 16'sh7FFF));
    dir_q.push_back(mk_frame(8'h00, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1, 16'sh7FFF, 16'sh8000));
    dir_q.push_back(mk_frame(8'h00, 16'sd100, -16'sd100, 1'b1, 1'b1, 16'sd0, 16'sd0));
    // invalid line still takes a slot
    dir_q.push_back(mk_frame(8'h00, 16'sd5, 16'sd5, 1'b0, 1'b1, -16'sd1, 16'sd1));
    dir_q.push_back(mk_frame(8'h00, 16'sd7, -16'sd7, 1'b1, 1'b1, 16'sd3, -16'sd3));
    // window full, then wraps over entry zero
    dir_q.push_back(mk_frame(8'h00, -16'sd2, 16'sd9, 1'b1, 1'b1, 16'sd3, 16'sd3));
    dir_q.push_back(mk_frame(8'h00, 16'sd7, 16'sd7, 1'b1, 1'b1, 16'sd3, -16'sd9));
    dir_q.push_back(mk_frame(8'h00, 16'sd7, 16'sd0, 1'b0, 1'b1, 16'sh5555, 16'shAAAA));
    // source change clears the control window only
    dir_q.push_back(mk_frame(8'hFF, 16'sd1, 16'sd2, 1'b1, 1'b1, 16'sd4, 16'sd4));
    // no end line clears the end window, raw end values go out
    dir_q.push_back(mk_frame(8'hFF, 16'sd1, 16'sd2, 1'b1, 1'b0, 16'shAAAA, 16'sh5555));
    dir_q.push_back(mk_frame(8'hFF, 16'sd3, 16'sd2, 1'b1, 1'b1, 16'sd8, 16'sd8));
    dir_q.push_back(mk_frame(8'hFF, 16'sh5555, 16'shAAAA, 1'b1, 1'b1, 16'sd8, 16'sd8));
    dir_q.push_back(mk_frame(8'hFF, 16'shAAAA, 16'sh5555, 1'b1, 1'b1, 16'sd8, -16'sd8));
    dir_q.push_back(mk_frame(8'h55, 16'shFFFF, 16'shFFFF, 1'b0, 1'b1, 16'shFFFF, 16'sd0));
    dir_q.push_back(mk_frame(8'h55, 16'sd0, 16'sd0, 1'b0, 1'b1, 16'sd0, 16'shFFFF));
    dir_q.push_back(mk_frame(8'h55, 16'sd0, 16'sd0, 1'b1, 1'b0, 16'sd0, 16'sd0));
    dir_q.push_back(mk_frame(8'hAA, 16'sd11, 16'sd12, 1'b1, 1'b1, 16'sd1, 16'sd1));
    dir_q.push_back(mk_frame(8'hAA, 16'sd11, 16'sd12, 1'b1, 1'b1, 16'sd1, 16'sd1));
    dir_q.push_back(mk_frame(8'hAA, 16'sd13, 16'sd10, 1'b1, 1'b1, 16'sd2, 16'sd0));
    dir_q.push_back(mk_frame(8'hAA, 16'sd10, 16'sd13, 1'b1, 1'b1, 16'sd0, 16'sd2));
    foreach (dir_q[i]) begin
      send_frame(dir_q[i]);
      if (i % 3 == 2) idle_cycles($urandom_range(1, 12));
    end
    cur_src = 8'hAA;
  endtask

  // zero smooths every valid line and present end line, seven never does
  task automatic test_special_thresholds();
    set_min_valid(3'd0);
    send_bursts(30);
    set_min_valid(3'd7);
    send_bursts(30);
  endtask

  task automatic test_random_traffic();
    logic [MV_W-1:0] mv_list [5];
    mv_list = '{3'd1, 3'd5, 3'd2, 3'd4, 3'd3};
    foreach (mv_list[i]) begin
      set_min_valid(mv_list[i]);
      send_bursts(80);
    end
  endtask

  // output held off long enough that the block backs up into its input
  task automatic test_output_backpressure();
    set_min_valid(3'd2);
    hold_req = 400;
    repeat (50) send_frame(random_frame());
    idle_cycles(5);
  endtask

  task automatic test_drain_pause();
    send_bursts(15);
    wait_all_filtered();
    send_bursts(15);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_special_thresholds();
    test_random_traffic();
    test_output_backpressure();
    test_drain_pause();
    wait_all_filtered();
    repeat (60) @(posedge clk_i);
    if (n_fail == 0 && pending_filtered_q.size() == 0) begin
      $display("tb_masked_sliding_median_filter OK");
    end else begin
      $display("tb_masked_sliding_median_filter NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_masked_sliding_median_filter NOT OK");
    $finish;
  end

endmodule
